FILE: rtl/chs_pkg.sv
// Shared constants, codes and control structures of the chained hash key set.
package chs_pkg;

    localparam int BUCKETS_DEF    = 64;
    localparam int POOL_NODES_DEF = 64;

    localparam int KEY_W    = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;

    localparam logic [KEY_W-1:0] EMPTY_KEY = '1;
    localparam logic [KEY_W-1:0] HASH_SEED = KEY_W'(5381);

    localparam logic [FUNC_W-1:0] FN_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FN_NONE   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic load;
        logic hash_step;
        logic mod_step;
        logic walk_init;
        logic walk_eval;
        logic walk_adv;
        logic wr_empty_key;
        logic wr_rm_key;
        logic wr_new_node;
        logic wr_tail_link;
        logic clr_init;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic key_bad;
        logic match;
        logic link_ok;
        logic steps_done;
        logic have_empty;
        logic pool_full;
        logic clr_last;
    } t_stat;

endpackage

FILE: rtl/chs_datapath.sv
// Datapath of the chained hash key set: hash, modulo, bucket and pool memories, chain walk.
module chs_datapath #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  chs_pkg::t_cmd                    i_cmd,
    input  logic signed [chs_pkg::KEY_W-1:0] i_key,
    output chs_pkg::t_stat                   o_stat
);
    import chs_pkg::*;

    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW = $clog2(BUCKETS) + 1;
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam int PW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;

    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] r_kshift;
    logic [KEY_W-1:0] r_hash;
    logic [RW-1:0]    r_rem;
    logic [RW-1:0]    n_rem;

    logic [LW-1:0] r_slot;
    logic [LW-1:0] r_steps;
    logic [LW-1:0] r_empty_slot;
    logic [LW-1:0] r_tail;
    logic [LW-1:0] r_used;
    logic          r_have_empty;
    logic [BW-1:0] r_clr_addr;

    logic [KEY_W-1:0] r_head_key_mem  [BUCKETS];
    logic [LW-1:0]    r_head_link_mem [BUCKETS];
    logic [KEY_W-1:0] r_pool_key_mem  [POOL_NODES];
    logic [LW-1:0]    r_pool_link_mem [POOL_NODES];

    logic [KEY_W-1:0] r_head_key_q;
    logic [LW-1:0]    r_head_link_q;
    logic [KEY_W-1:0] r_pool_key_q;
    logic [LW-1:0]    r_pool_link_q;

    logic [KEY_W-1:0] w_q_key;
    logic [LW-1:0]    w_q_link;
    logic [LW-1:0]    w_q_link_m1;
    logic [PW-1:0]    w_pool_raddr;
    logic [LW-1:0]    w_tgt;
    logic [LW-1:0]    w_tgt_m1;
    logic [PW-1:0]    w_pool_waddr;
    logic [BW-1:0]    w_head_waddr;
    logic             w_tgt_head;
    logic             w_hk_we;
    logic             w_hl_we;
    logic             w_pk_we;
    logic             w_pl_we;
    logic [KEY_W-1:0] w_key_wdata;
    logic [LW-1:0]    w_link_wdata;

    // The remainder is built eight hash bits a cycle, most significant bit first.
    always_comb begin
        n_rem = r_rem;
        for (int i = 0; i < BYTE_W; i++) begin
            n_rem = (n_rem << 1) | RW'(r_hash[KEY_W-1-i]);
            if (n_rem >= RW'(BUCKETS)) begin
                n_rem = n_rem - RW'(BUCKETS);
            end
        end
    end

    assign w_q_key      = (r_slot == '0) ? r_head_key_q : r_pool_key_q;
    assign w_q_link     = (r_slot == '0) ? r_head_link_q : r_pool_link_q;
    assign w_q_link_m1  = w_q_link - LW'(1);
    assign w_pool_raddr = w_q_link_m1[PW-1:0];

    assign w_tgt        = i_cmd.wr_empty_key ? r_empty_slot :
                          (i_cmd.wr_rm_key ? r_slot : r_tail);
    assign w_tgt_m1     = w_tgt - LW'(1);
    assign w_tgt_head   = (w_tgt == '0);
    assign w_pool_waddr = i_cmd.wr_new_node ? r_used[PW-1:0] : w_tgt_m1[PW-1:0];
    assign w_head_waddr = i_cmd.clr_step ? r_clr_addr : r_rem[BW-1:0];

    assign w_key_wdata  = (i_cmd.wr_empty_key || i_cmd.wr_new_node) ? r_key : EMPTY_KEY;
    assign w_link_wdata = (i_cmd.wr_tail_link && !i_cmd.clr_step) ? r_used : '0;

    assign w_hk_we = i_cmd.clr_step ||
                     ((i_cmd.wr_empty_key || i_cmd.wr_rm_key) && w_tgt_head);
    assign w_hl_we = i_cmd.clr_step || (i_cmd.wr_tail_link && w_tgt_head);
    assign w_pk_we = i_cmd.wr_new_node ||
                     ((i_cmd.wr_empty_key || i_cmd.wr_rm_key) && !w_tgt_head);
    assign w_pl_we = i_cmd.wr_new_node || (i_cmd.wr_tail_link && !w_tgt_head);

    always_ff @(posedge i_clk) begin
        if (w_hk_we) begin
            r_head_key_mem[w_head_waddr] <= w_key_wdata;
        end
        r_head_key_q <= r_head_key_mem[r_rem[BW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_hl_we) begin
            r_head_link_mem[w_head_waddr] <= w_link_wdata;
        end
        r_head_link_q <= r_head_link_mem[r_rem[BW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_pk_we) begin
            r_pool_key_mem[w_pool_waddr] <= w_key_wdata;
        end
        r_pool_key_q <= r_pool_key_mem[w_pool_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_pl_we) begin
            r_pool_link_mem[w_pool_waddr] <= w_link_wdata;
        end
        r_pool_link_q <= r_pool_link_mem[w_pool_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= $unsigned(i_key);
            r_kshift <= $unsigned(i_key);
            r_hash   <= HASH_SEED;
            r_rem    <= '0;
        end else if (i_cmd.hash_step) begin
            r_hash   <= ((r_hash << 5) + r_hash) ^
                        {{(KEY_W-BYTE_W){1'b0}}, r_kshift[BYTE_W-1:0]};
            r_kshift <= r_kshift >> BYTE_W;
        end else if (i_cmd.mod_step) begin
            r_rem  <= n_rem;
            r_hash <= r_hash << BYTE_W;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_slot       <= '0;
            r_steps      <= '0;
            r_have_empty <= 1'b0;
        end else begin
            if (i_cmd.walk_eval) begin
                r_tail <= r_slot;
                if ((w_q_key == EMPTY_KEY) && !r_have_empty) begin
                    r_have_empty <= 1'b1;
                    r_empty_slot <= r_slot;
                end
            end
            if (i_cmd.walk_adv) begin
                r_slot  <= w_q_link;
                r_steps <= r_steps + LW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_clr_addr <= '0;
        end else begin
            if (i_cmd.clr_init) begin
                r_used     <= '0;
                r_clr_addr <= '0;
            end else begin
                if (i_cmd.wr_new_node) begin
                    r_used <= r_used + LW'(1);
                end
                if (i_cmd.clr_step) begin
                    r_clr_addr <= r_clr_addr + BW'(1);
                end
            end
        end
    end

    assign o_stat.key_bad    = ($unsigned(i_key) == EMPTY_KEY);
    assign o_stat.match      = (w_q_key == r_key);
    assign o_stat.link_ok    = (w_q_link != '0) && (w_q_link <= r_used);
    assign o_stat.steps_done = (r_steps >= LW'(POOL_NODES));
    assign o_stat.have_empty = r_have_empty;
    assign o_stat.pool_full  = (r_used >= LW'(POOL_NODES));
    assign o_stat.clr_last   = (r_clr_addr == BW'(BUCKETS - 1));

endmodule

FILE: rtl/chs_ctrl.sv
// Controller state machine of the chained hash key set.
module chs_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [chs_pkg::FUNC_W-1:0]        i_func,
    input  chs_pkg::t_stat                    i_stat,
    output chs_pkg::t_cmd                     o_cmd,
    output logic                              o_busy,
    output logic                              o_strobe,
    output logic [chs_pkg::STATUS_W-1:0]      o_status
);
    import chs_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HASH  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_FETCH = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_LINK  = 3'd6;
    localparam logic [2:0] S_CLEAR = 3'd7;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [1:0]          r_cnt;
    logic [1:0]          n_cnt;
    logic [FUNC_W-1:0]   r_func;
    logic [FUNC_W-1:0]   n_func;
    logic                r_resp;
    logic                n_resp;
    logic                r_strobe;
    logic                n_strobe;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;
    t_cmd                w_cmd;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_func   = r_func;
        n_resp   = r_resp;
        n_strobe = 1'b0;
        n_status = r_status;
        w_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_func = i_func;
                    case (i_func)
                        FN_ADD, FN_REMOVE: begin
                            if (i_stat.key_bad) begin
                                n_strobe = 1'b1;
                                n_status = ST_NOT;
                            end else begin
                                w_cmd.load = 1'b1;
                                n_cnt      = '0;
                                n_state    = S_HASH;
                            end
                        end
                        FN_CLEAR: begin
                            w_cmd.clr_init = 1'b1;
                            n_resp         = 1'b1;
                            n_state        = S_CLEAR;
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_status = ST_NOT;
                        end
                    endcase
                end
            end
            S_HASH: begin
                w_cmd.hash_step = 1'b1;
                n_cnt           = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                w_cmd.mod_step = 1'b1;
                n_cnt          = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                w_cmd.walk_init = 1'b1;
                n_state         = S_WALK;
            end
            S_WALK: begin
                w_cmd.walk_eval = 1'b1;
                if (i_stat.match) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (r_func == FN_ADD) begin
                        n_status = ST_NOT;
                    end else begin
                        w_cmd.wr_rm_key = 1'b1;
                        n_status        = ST_DONE;
                    end
                end else if (i_stat.link_ok && !i_stat.steps_done) begin
                    w_cmd.walk_adv = 1'b1;
                end else if (r_func == FN_ADD) begin
                    n_state = S_FIN;
                end else begin
                    n_strobe = 1'b1;
                    n_status = ST_NOT;
                    n_state  = S_IDLE;
                end
            end
            S_FIN: begin
                if (i_stat.have_empty) begin
                    w_cmd.wr_empty_key = 1'b1;
                    n_strobe           = 1'b1;
                    n_status           = ST_DONE;
                    n_state            = S_IDLE;
                end else if (i_stat.pool_full) begin
                    n_strobe = 1'b1;
                    n_status = ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    w_cmd.wr_new_node = 1'b1;
                    n_state           = S_LINK;
                end
            end
            S_LINK: begin
                w_cmd.wr_tail_link = 1'b1;
                n_strobe           = 1'b1;
                n_status           = ST_DONE;
                n_state            = S_IDLE;
            end
            S_CLEAR: begin
                w_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                    if (r_resp) begin
                        n_strobe = 1'b1;
                        n_status = ST_DONE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_cnt    <= '0;
            r_resp   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_resp   <= n_resp;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func   <= n_func;
        r_status <= n_status;
    end

    assign o_cmd    = w_cmd;
    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_status = r_status;

endmodule

FILE: rtl/chained_hash_key_set.sv
// Top level of the chained hash key set: controller, datapath and checks.
//
// A word is accepted when start is high while busy is low, and each accepted word yields
// exactly one status word on o_status, marked by o_strobe for a single cycle; the receiver
// cannot stall it. An add or remove hashes the key, reduces the hash and walks the chain of
// its bucket (the head and each overflow node); an add that finds no match then fills an
// empty slot or reports the pool full, or appends a pool node and links it to the tail:
// the hash steps take in one key byte each, the modulo steps reduce the hash modulo BUCKETS
// eight bits at a time, and the walk reads one slot per cycle from the bucket or pool
// memory. A clear writes one bucket per cycle. Invalid keys and unused functions are
// answered in the cycle after acceptance. After reset busy stays high for a clearing pass
// over the bucket memory, which produces no status word.
module chained_hash_key_set #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [chs_pkg::FUNC_W-1:0]       i_func,
    input  logic signed [chs_pkg::KEY_W-1:0] i_key,
    output logic                             o_strobe,
    output logic [chs_pkg::STATUS_W-1:0]     o_status
);
    import chs_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    chs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe),
        .o_status (o_status)
    );

    chs_datapath #(
        .BUCKETS    (BUCKETS),
        .POOL_NODES (POOL_NODES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_key   (i_key),
        .o_stat  (w_stat)
    );

    a_unused_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FN_NONE) |=> (o_strobe && o_status == ST_NOT))
        else $error("unused function did not report not done");

    a_bad_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FN_ADD || i_func == FN_REMOVE) &&
         $unsigned(i_key) == EMPTY_KEY) |=> (o_strobe && o_status == ST_NOT))
        else $error("empty key marker was not rejected");

    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == FN_CLEAR) |=> (busy && !o_strobe))
        else $error("clear did not start its sweep");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start || busy))
        else $error("status word without an operation");

endmodule
